// ===== design/hepm_pkg.sv =====
package hepm_pkg;

    // default geometry
    localparam int FRAME_WIDTH_DEF   = 512;
    localparam int FRAME_HEIGHT_DEF  = 512;
    localparam int SEARCH_RADIUS_DEF = 1;

    // datapath widths
    localparam int ACC_W     = 44;  // X, Y, W accumulators
    localparam int NUM_W     = 61;  // X*2^15 + W, also dividend magnitude / quotient
    localparam int DEN_W     = 46;  // 2*W
    localparam int QUO_W     = 62;  // signed projected coordinate
    localparam int DIV_CNT_W = 6;
    localparam int SCAN_W    = 3;   // neighbor index, radius up to 3
    localparam int DIFF_W    = 19;
    localparam int ANGLE_TOL = 128; // half a degree in Q8.8

    // register indexes
    localparam logic [2:0] CFG_COEF_XX      = 3'd0;
    localparam logic [2:0] CFG_COEF_XY      = 3'd1;
    localparam logic [2:0] CFG_COEF_X_SHIFT = 3'd2;
    localparam logic [2:0] CFG_COEF_YX      = 3'd3;
    localparam logic [2:0] CFG_COEF_YY      = 3'd4;
    localparam logic [2:0] CFG_COEF_Y_SHIFT = 3'd5;
    localparam logic [2:0] CFG_PERSP        = 3'd6;
    localparam logic [2:0] CFG_ANGLE_OFFSET = 3'd7;

    localparam logic [31:0] COEF_ONE   = 32'h0001_0000;
    localparam logic [31:0] COEF_ZERO  = 32'h0000_0000;
    localparam logic [63:0] PERSP_ZERO = 64'h0;
    localparam logic [16:0] OFFSET_ZERO = 17'h0;

    // product selects of the shared multiplier
    localparam logic [2:0] MUL_XX = 3'd0;
    localparam logic [2:0] MUL_XY = 3'd1;
    localparam logic [2:0] MUL_YX = 3'd2;
    localparam logic [2:0] MUL_YY = 3'd3;
    localparam logic [2:0] MUL_PX = 3'd4;
    localparam logic [2:0] MUL_PY = 3'd5;

    typedef struct packed {
        logic              latch;     // capture query fields
        logic              load_wr;   // map write from input ports
        logic              mul_en;
        logic [2:0]        mul_idx;
        logic              div_load;
        logic              div_sel;   // 0: column, 1: row
        logic              div_step;
        logic              div_store;
        logic              scan_rd;
        logic [SCAN_W-1:0] scan_dx;
        logic [SCAN_W-1:0] scan_dy;
        logic              set_degen;
    } cmd_t;

    typedef struct packed {
        logic w_zero;
    } stat_t;

endpackage

// ===== design/hepm_ram.sv =====
module hepm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hepm_ctrl.sv =====
module hepm_ctrl #(
    parameter int SEARCH_RADIUS = hepm_pkg::SEARCH_RADIUS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            mode,
    input  hepm_pkg::stat_t stat,
    output hepm_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIVL = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_SCAN = 3'd6;
    localparam logic [2:0] S_LAST = 3'd7;

    localparam logic [hepm_pkg::SCAN_W-1:0] SCAN_LAST =
        hepm_pkg::SCAN_W'(2 * SEARCH_RADIUS);
    localparam logic [hepm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        hepm_pkg::DIV_CNT_W'(hepm_pkg::NUM_W - 1);

    logic [2:0]                        state_reg, state_next;
    logic [2:0]                        mul_reg, mul_next;
    logic [hepm_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              sel_reg, sel_next;
    logic [hepm_pkg::SCAN_W-1:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic                              done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        mul_next   = mul_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.mul_idx = mul_reg;
        cmd.div_sel = sel_reg;
        cmd.scan_dx = dx_reg;
        cmd.scan_dy = dy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // no request is taken while the result is on the ports
                if (start && !done_reg)
                begin
                    if (mode)
                    begin
                        cmd.latch  = 1'b1;
                        mul_next   = hepm_pkg::MUL_XX;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                mul_next   = mul_reg + 3'd1;
                if (mul_reg == hepm_pkg::MUL_PY)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.w_zero)
                begin
                    cmd.set_degen = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    sel_next   = 1'b0;
                    state_next = S_DIVL;
                end
            end
            S_DIVL:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.div_store = 1'b1;
                if (sel_reg)
                begin
                    dx_next    = '0;
                    dy_next    = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = S_DIVL;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (dx_reg == SCAN_LAST)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 1'b1;
                    if (dy_reg == SCAN_LAST)
                    begin
                        state_next = S_LAST;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                // last neighbor read lands this cycle
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mul_reg   <= '0;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mul_reg   <= mul_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

endmodule

// ===== design/hepm_datapath.sv =====
module hepm_datapath #(
    parameter int FRAME_WIDTH   = hepm_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT  = hepm_pkg::FRAME_HEIGHT_DEF,
    parameter int SEARCH_RADIUS = hepm_pkg::SEARCH_RADIUS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hepm_pkg::cmd_t     cmd,
    output hepm_pkg::stat_t    stat,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic [8:0]         pos_x,
    input  logic [8:0]         pos_y,
    input  logic               edge_bit,
    input  logic signed [15:0] angle,
    output logic [8:0]         point_x,
    output logic [8:0]         point_y,
    output logic               matched,
    output logic               degenerate
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CX_W   = $clog2(FRAME_WIDTH);
    localparam int CY_W   = $clog2(FRAME_HEIGHT);
    localparam int AW = hepm_pkg::ACC_W;
    localparam int NW = hepm_pkg::NUM_W;
    localparam int DW = hepm_pkg::DEN_W;
    localparam int QW = hepm_pkg::QUO_W;
    localparam int SW = hepm_pkg::SCAN_W;

    // configuration
    logic [31:0] coef_xx_reg, coef_xy_reg, coef_xs_reg;
    logic [31:0] coef_yx_reg, coef_yy_reg, coef_ys_reg;
    logic [63:0] persp_reg;
    logic [16:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= hepm_pkg::COEF_ONE;
            coef_xy_reg <= hepm_pkg::COEF_ZERO;
            coef_xs_reg <= hepm_pkg::COEF_ZERO;
            coef_yx_reg <= hepm_pkg::COEF_ZERO;
            coef_yy_reg <= hepm_pkg::COEF_ONE;
            coef_ys_reg <= hepm_pkg::COEF_ZERO;
            persp_reg   <= hepm_pkg::PERSP_ZERO;
            offset_reg  <= hepm_pkg::OFFSET_ZERO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hepm_pkg::CFG_COEF_XX:      coef_xx_reg <= cfg_data[31:0];
                hepm_pkg::CFG_COEF_XY:      coef_xy_reg <= cfg_data[31:0];
                hepm_pkg::CFG_COEF_X_SHIFT: coef_xs_reg <= cfg_data[31:0];
                hepm_pkg::CFG_COEF_YX:      coef_yx_reg <= cfg_data[31:0];
                hepm_pkg::CFG_COEF_YY:      coef_yy_reg <= cfg_data[31:0];
                hepm_pkg::CFG_COEF_Y_SHIFT: coef_ys_reg <= cfg_data[31:0];
                hepm_pkg::CFG_PERSP:        persp_reg   <= cfg_data;
                hepm_pkg::CFG_ANGLE_OFFSET: offset_reg  <= cfg_data[16:0];
                default:                    offset_reg  <= offset_reg;
            endcase
        end
    end

    // query capture
    logic [8:0]         qx_reg, qy_reg;
    logic signed [15:0] qang_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            qx_reg   <= pos_x;
            qy_reg   <= pos_y;
            qang_reg <= angle;
        end
    end

    // shared multiplier with accumulator
    logic signed [31:0] mul_coef;
    logic signed [9:0]  mul_opnd;
    logic signed [41:0] prod;
    logic signed [AW-1:0] prod_ext, base, acc_sum;
    logic signed [AW-1:0] acc_reg, xn_reg, yn_reg, w_reg;

    always_comb
    begin
        unique case (cmd.mul_idx)
            hepm_pkg::MUL_XX: mul_coef = coef_xx_reg;
            hepm_pkg::MUL_XY: mul_coef = coef_xy_reg;
            hepm_pkg::MUL_YX: mul_coef = coef_yx_reg;
            hepm_pkg::MUL_YY: mul_coef = coef_yy_reg;
            hepm_pkg::MUL_PX: mul_coef = persp_reg[31:0];
            hepm_pkg::MUL_PY: mul_coef = persp_reg[63:32];
            default:          mul_coef = '0;
        endcase
        mul_opnd = cmd.mul_idx[0] ? {1'b0, qy_reg} : {1'b0, qx_reg};
        prod     = mul_coef * mul_opnd;
        prod_ext = {{(AW-42){prod[41]}}, prod};
        unique case (cmd.mul_idx[2:1])
            2'd0:    base = {{(AW-32){coef_xs_reg[31]}}, coef_xs_reg};
            2'd1:    base = {{(AW-32){coef_ys_reg[31]}}, coef_ys_reg};
            default: base = AW'(64'sd1 <<< 30);
        endcase
        acc_sum = (cmd.mul_idx[0] ? acc_reg : base) + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            acc_reg <= acc_sum;
            if (cmd.mul_idx == hepm_pkg::MUL_XY) xn_reg <= acc_sum;
            if (cmd.mul_idx == hepm_pkg::MUL_YY) yn_reg <= acc_sum;
            if (cmd.mul_idx == hepm_pkg::MUL_PY) w_reg  <= acc_sum;
        end
    end

    assign stat.w_zero = (w_reg == '0);

    // restoring divider, one quotient bit a cycle, on magnitudes
    logic signed [AW-1:0] num_src;
    logic signed [NW-1:0] n_val;
    logic signed [DW-1:0] d_val;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] dmag_reg, rem_reg, trial;
    logic          qneg_reg, trial_ok;
    logic [QW-1:0] q_ext, q_signed;
    logic signed [QW-1:0] wx_reg, wy_reg;

    always_comb
    begin
        num_src  = cmd.div_sel ? yn_reg : xn_reg;
        n_val    = ({{(NW-AW){num_src[AW-1]}}, num_src} <<< 15)
                 + {{(NW-AW){w_reg[AW-1]}}, w_reg};
        d_val    = {{(DW-AW){w_reg[AW-1]}}, w_reg} <<< 1;
        trial    = {rem_reg[DW-2:0], q_reg[NW-1]};
        trial_ok = (trial >= dmag_reg);
        q_ext    = {{(QW-NW){1'b0}}, q_reg};
        q_signed = qneg_reg ? (~q_ext + 1'b1) : q_ext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            q_reg    <= n_val[NW-1] ? NW'(-n_val) : NW'(n_val);
            dmag_reg <= d_val[DW-1] ? DW'(-d_val) : DW'(d_val);
            qneg_reg <= n_val[NW-1] ^ d_val[DW-1];
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ok ? (trial - dmag_reg) : trial;
            q_reg   <= {q_reg[NW-2:0], trial_ok};
        end
        if (cmd.div_store)
        begin
            if (cmd.div_sel) wy_reg <= q_signed;
            else             wx_reg <= q_signed;
        end
    end

    // neighbor scan
    logic signed [SW:0] off_x, off_y;
    logic signed [QW:0] nx, ny;
    logic               nb_in;
    logic [ADDR_W-1:0]  scan_addr, load_addr, ram_addr;
    logic               load_in, ram_we;
    logic [16:0]        ram_rdata;

    always_comb
    begin
        off_x = $signed({1'b0, cmd.scan_dx}) - $signed((SW+1)'(SEARCH_RADIUS));
        off_y = $signed({1'b0, cmd.scan_dy}) - $signed((SW+1)'(SEARCH_RADIUS));
        nx = {wx_reg[QW-1], wx_reg} + {{(QW-SW){off_x[SW]}}, off_x};
        ny = {wy_reg[QW-1], wy_reg} + {{(QW-SW){off_y[SW]}}, off_y};
        nb_in = !nx[QW] && (nx < (QW+1)'(FRAME_WIDTH))
             && !ny[QW] && (ny < (QW+1)'(FRAME_HEIGHT));
        scan_addr = ADDR_W'(32'(ny[CY_W-1:0]) * FRAME_WIDTH + 32'(nx[CX_W-1:0]));
        load_in   = (32'(pos_x) < FRAME_WIDTH) && (32'(pos_y) < FRAME_HEIGHT);
        load_addr = ADDR_W'(32'(pos_y) * FRAME_WIDTH + 32'(pos_x));
        ram_we    = cmd.load_wr && load_in;
        ram_addr  = cmd.load_wr ? load_addr : scan_addr;
    end

    hepm_ram #(
        .WIDTH (17),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({edge_bit, angle}),
        .rdata (ram_rdata)
    );

    logic eval_reg, inb_reg, match_reg, degen_reg;
    logic signed [hepm_pkg::DIFF_W-1:0] diff;
    logic hit;

    always_comb
    begin
        diff = $signed({{3{ram_rdata[15]}}, ram_rdata[15:0]})
             - $signed({{3{qang_reg[15]}}, qang_reg})
             - $signed({{2{offset_reg[16]}}, offset_reg});
        hit  = inb_reg && ram_rdata[16]
            && (diff < hepm_pkg::DIFF_W'(hepm_pkg::ANGLE_TOL))
            && (diff > -hepm_pkg::DIFF_W'(hepm_pkg::ANGLE_TOL));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg  <= 1'b0;
            inb_reg   <= 1'b0;
            match_reg <= 1'b0;
            degen_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= cmd.scan_rd;
            inb_reg  <= nb_in;
            if (cmd.latch)
            begin
                match_reg <= 1'b0;
                degen_reg <= 1'b0;
            end
            else
            begin
                if (cmd.set_degen) degen_reg <= 1'b1;
                if (eval_reg && hit) match_reg <= 1'b1;
            end
        end
    end

    assign point_x    = qx_reg;
    assign point_y    = qy_reg;
    assign matched    = match_reg;
    assign degenerate = degen_reg;

endmodule

// ===== design/homography_edge_point_matcher.sv =====
// Channel   | Handshake        | Payload
// ----------+------------------+------------------------------------------------
// request   | start / busy     | mode, pos_x, pos_y, edge_bit, angle
// result    | done (1 cycle)   | point_x, point_y, matched, degenerate
// config    | cfg_we           | cfg_index, cfg_data
//
// A request is taken when start is high and busy is low.
// Load: writes the map pixel at that edge, busy stays low.
// Query: six multiply steps, a w check, two divides (one quotient
// bit a cycle), (2*SEARCH_RADIUS+1)^2 map reads (one per cycle on the single
// map port), then a drain state before done; a zero w ends at the w check.
// busy stays high through the done cycle.
// Reset (rst_n low, async) restores the register defaults; the map has no
// clear and must be loaded before it is read. Results cannot be stalled.
module homography_edge_point_matcher #(
    parameter int FRAME_WIDTH   = hepm_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT  = hepm_pkg::FRAME_HEIGHT_DEF,
    parameter int SEARCH_RADIUS = hepm_pkg::SEARCH_RADIUS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [8:0]         pos_x,
    input  logic [8:0]         pos_y,
    input  logic               edge_bit,
    input  logic signed [15:0] angle,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output logic               done,
    output logic [8:0]         point_x,
    output logic [8:0]         point_y,
    output logic               matched,
    output logic               degenerate
);

    hepm_pkg::cmd_t  cmd;
    hepm_pkg::stat_t stat;

    // sequencer: multiply, divide, scan
    hepm_ctrl #(
        .SEARCH_RADIUS (SEARCH_RADIUS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // projection arithmetic, edge map and match test
    hepm_datapath #(
        .FRAME_WIDTH   (FRAME_WIDTH),
        .FRAME_HEIGHT  (FRAME_HEIGHT),
        .SEARCH_RADIUS (SEARCH_RADIUS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .edge_bit   (edge_bit),
        .angle      (angle),
        .point_x    (point_x),
        .point_y    (point_y),
        .matched    (matched),
        .degenerate (degenerate)
    );

endmodule
